@@ rtl/core/mdbc_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mdbc_pkg
// types, codes and widths shared by the manual drive boost controller
// -----------------------------------------------------------------------------
package mdbc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;
	localparam int CNT_W      = 4;
	localparam int RES_MAX    = 5;
	localparam int RES_IDX_W  = 3;
	localparam int SQRT_STEPS = 16;
	localparam int DIV_STEPS  = 8;
	localparam int GDIV_STEPS = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_RANGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESEND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL       = 3'd5;

	// request types
	localparam logic [1:0] REQ_PRESS   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;
	localparam logic [1:0] REQ_NONE    = 2'd3;

	// buttons
	localparam logic [2:0] KEY_A     = 3'd0;
	localparam logic [2:0] KEY_B     = 3'd1;
	localparam logic [2:0] KEY_MENU  = 3'd2;
	localparam logic [2:0] KEY_UP    = 3'd3;
	localparam logic [2:0] KEY_DOWN  = 3'd4;
	localparam logic [2:0] KEY_LEFT  = 3'd5;
	localparam logic [2:0] KEY_RIGHT = 3'd6;
	localparam logic [2:0] KEY_OTHER = 3'd7;

	// direction bits
	localparam logic [3:0] DIR_UP    = 4'b0001;
	localparam logic [3:0] DIR_DOWN  = 4'b0010;
	localparam logic [3:0] DIR_LEFT  = 4'b0100;
	localparam logic [3:0] DIR_RIGHT = 4'b1000;

	// message kinds
	localparam logic [2:0] KIND_DRIVE = 3'd0;
	localparam logic [2:0] KIND_SPEED = 3'd1;
	localparam logic [2:0] KIND_BOOST = 3'd2;
	localparam logic [2:0] KIND_HONK  = 3'd3;
	localparam logic [2:0] KIND_GAUGE = 3'd4;

	localparam logic [6:0] GAUGE_FULL = 7'd100;
	localparam logic [6:0] GAUGE_SAT  = 7'd127;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         button;
		logic [19:0]        elapsed_us;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic               accel_present;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] dir;
		logic [7:0] speed;
		logic       flag;
		logic [6:0] level;
	} msg_t;

	typedef struct packed {
		logic load;
		logic sq;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic eval_a;
		logic gmul;
		logic gdiv_init;
		logic gdiv_step;
		logic eval_b;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic gauge_go;
		logic empty;
		logic last;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_SQRT,
		S_DINIT,
		S_DIV,
		S_EVAL_A,
		S_GMUL,
		S_GDINIT,
		S_GDIV,
		S_EVAL_B,
		S_EMIT
	} state_t;

endpackage

@@ rtl/core/mdbc_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mdbc channel interfaces
// request, result and register write channels with valid/ready
// -----------------------------------------------------------------------------
interface mdbc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [2:0]         button;
	logic [19:0]        elapsed_us;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               accel_present;

	modport source (output valid, req_type, button, elapsed_us, accel_x, accel_y,
		accel_z, accel_present, input ready);
	modport sink (input valid, req_type, button, elapsed_us, accel_x, accel_y,
		accel_z, accel_present, output ready);
endinterface

interface mdbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] msg_kind;
	logic [3:0] drive_dir;
	logic [7:0] drive_speed;
	logic       boost_flag;
	logic [6:0] gauge_level;
	logic       last_of_run;

	modport source (output valid, msg_kind, drive_dir, drive_speed, boost_flag,
		gauge_level, last_of_run, input ready);
	modport sink (input valid, msg_kind, drive_dir, drive_speed, boost_flag,
		gauge_level, last_of_run, output ready);
endinterface

interface mdbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [25:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/mdbc_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mdbc_ctrl
// sequencer: steps the datapath through tilt, speed, gauge and emission
// -----------------------------------------------------------------------------
module mdbc_ctrl
	import mdbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1))
					state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_EVAL_A;
			end
			S_EVAL_A: begin
				cmd.eval_a = 1'b1;
				state_d    = sts.gauge_go ? S_GMUL : S_EMIT;
			end
			S_GMUL: begin
				cmd.gmul = 1'b1;
				state_d  = S_GDINIT;
			end
			S_GDINIT: begin
				cmd.gdiv_init = 1'b1;
				cnt_d         = '0;
				state_d       = S_GDIV;
			end
			S_GDIV: begin
				cmd.gdiv_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GDIV_STEPS - 1))
					state_d = S_EVAL_B;
			end
			S_EVAL_B: begin
				cmd.eval_b = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.empty) begin
					state_d = S_IDLE;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						if (sts.last)
							state_d = S_IDLE;
						else
							cmd.emit_next = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/core/mdbc_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mdbc_dp
// datapath: registers, tilt, isqrt, dividers, event logic and result buffer
// -----------------------------------------------------------------------------
module mdbc_dp
	import mdbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output msg_t                  res,
	output logic                  res_last
);

	function automatic logic signed [15:0] clampr(logic signed [16:0] v,
		logic signed [16:0] r);
		if (v > r) return r[15:0];
		if (v < -r) return 16'(-r);
		return v[15:0];
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [19:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [3:0] dir_bit(logic [2:0] b);
		case (b)
			KEY_UP:    return DIR_UP;
			KEY_DOWN:  return DIR_DOWN;
			KEY_LEFT:  return DIR_LEFT;
			KEY_RIGHT: return DIR_RIGHT;
			default:   return 4'b0000;
		endcase
	endfunction

	function automatic msg_t mk(logic [2:0] k, logic [3:0] d, logic [7:0] s,
		logic f, logic [6:0] l);
		msg_t m;
		m.kind  = k;
		m.dir   = d;
		m.speed = s;
		m.flag  = f;
		m.level = l;
		return m;
	endfunction

	// configuration
	logic [14:0] tr_q, dz_q;
	logic [7:0]  sfs_q;
	logic [19:0] rsi_q;
	logic [25:0] drn_q, fil_q;

	// controller state
	logic [3:0]  held_q, last_q;
	logic        bh_q, bon_q;
	logic [6:0]  gauge_q, gstart_q;
	logic [31:0] belap_q, relap_q;

	// current item
	logic [1:0]         req_q;
	logic [2:0]         btn_q;
	logic [19:0]        el_q;
	logic               present_q, tilt_ok_q;
	logic signed [15:0] x_q, y_q;
	logic [3:0]         cdir_q;

	// arithmetic units
	logic [31:0] rem_q, res_q, bit_q;
	logic [22:0] drem_q, ddvs_q;
	logic [7:0]  dquo_q;
	logic [38:0] prod_q;
	logic [32:0] grem_q, gdvs_q;
	logic [6:0]  gquo_q, goval_q;
	logic        gover_q;

	// results
	msg_t                 buf_q [RES_MAX];
	logic [RES_IDX_W-1:0] cnt_q, idx_q;

	logic signed [16:0] r17, d17, ax17, nay17, x17, y17;
	logic signed [31:0] xx, yy;
	logic [3:0]         cdir_d;
	logic [31:0]        sq_t;
	logic [15:0]        mag, m16;
	logic [14:0]        span, m15;
	logic [7:0]         spd;
	logic [25:0]        tsel;
	logic [6:0]         q7;

	assign r17   = {2'b00, tr_q};
	assign d17   = {2'b00, dz_q};
	assign ax17  = {item.accel_x[15], item.accel_x};
	assign nay17 = -{item.accel_y[15], item.accel_y};
	assign x17   = {x_q[15], x_q};
	assign y17   = {y_q[15], y_q};
	assign xx    = x_q * x_q;
	assign yy    = y_q * y_q;
	assign sq_t  = res_q + bit_q;
	assign mag   = res_q[15:0];
	assign span  = tr_q - dz_q;
	assign m16   = (mag > {1'b0, dz_q}) ? mag - {1'b0, dz_q} : 16'd0;
	assign m15   = (m16 > {1'b0, span}) ? span : m16[14:0];
	assign spd   = (tilt_ok_q && tr_q > dz_q) ? dquo_q : 8'd0;
	assign tsel  = bon_q ? drn_q : fil_q;
	assign q7    = gover_q ? goval_q : gquo_q;

	always_comb begin
		cdir_d = 4'b0000;
		if (present_q && tilt_ok_q) begin
			if (y17 < -d17) cdir_d = cdir_d | DIR_RIGHT;
			else if (y17 > d17) cdir_d = cdir_d | DIR_LEFT;
			if (x17 < -d17) cdir_d = cdir_d | DIR_DOWN;
			else if (x17 > d17) cdir_d = cdir_d | DIR_UP;
		end
	end

	// event handling before the gauge update
	logic [3:0]           a_h, a_ls;
	logic                 a_bh, a_bo, a_go;
	logic [6:0]           a_gs;
	logic [31:0]          a_be, a_re;
	msg_t                 a_buf [RES_MAX];
	logic [RES_IDX_W-1:0] a_n;

	function automatic msg_t drive_msg(logic [3:0] h, logic p, logic [3:0] cd,
		logic [7:0] s);
		if (h == 4'b0000 && p && s != 8'd0)
			return mk(KIND_SPEED, cd, s, 1'b0, 7'd0);
		return mk(KIND_DRIVE, h, 8'd0, 1'b0, 7'd0);
	endfunction

	always_comb begin
		msg_t m;
		logic on;
		m    = '0;
		a_h  = held_q;
		a_ls = last_q;
		a_bh = bh_q;
		a_bo = bon_q;
		a_gs = gstart_q;
		a_be = belap_q;
		a_re = relap_q;
		a_go = 1'b0;
		a_n  = '0;
		for (int i = 0; i < RES_MAX; i++)
			a_buf[i] = buf_q[i];
		on = (gauge_q != 7'd0) ? 1'b1 : bon_q;
		case (req_q)
			REQ_PRESS: begin
				if (btn_q == KEY_A) begin
					a_bh = 1'b1;
					if (a_h != 4'b0000) begin
						a_bo = on; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, on, 7'd0);
						a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
					end
				end else if (btn_q == KEY_B) begin
					a_buf[a_n] = mk(KIND_HONK, 4'd0, 8'd0, 1'b0, 7'd0);
					a_n = a_n + 1'b1;
				end else if (btn_q != KEY_MENU) begin
					if (a_bh) begin
						a_bo = on; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, on, 7'd0);
						a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
					end
					a_h = a_h | dir_bit(btn_q);
					m = drive_msg(a_h, present_q, cdir_q, spd);
					a_ls = m.dir; a_buf[a_n] = m; a_n = a_n + 1'b1;
					a_re = '0;
				end
			end
			REQ_RELEASE: begin
				if (btn_q == KEY_A) begin
					a_bh = 1'b0;
					if (a_bo) begin
						a_bo = 1'b0; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, 1'b0, 7'd0);
						a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
					end
				end else begin
					a_h = a_h & ~dir_bit(btn_q);
					m = drive_msg(a_h, present_q, cdir_q, spd);
					a_ls = m.dir; a_buf[a_n] = m; a_n = a_n + 1'b1;
					a_re = '0;
				end
				if (a_h == 4'b0000 && cdir_q == 4'b0000 && a_bo) begin
					a_bo = 1'b0; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, 1'b0, 7'd0);
					a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
				end
			end
			REQ_TICK: begin
				if (present_q) begin
					if (a_bh && cdir_q != 4'b0000 && !a_bo && gauge_q != 7'd0) begin
						a_bo = 1'b1; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, 1'b1, 7'd0);
						a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
					end
					if (a_h == 4'b0000 && cdir_q == 4'b0000 && a_bo) begin
						a_bo = 1'b0; a_buf[a_n] = mk(KIND_BOOST, 4'd0, 8'd0, 1'b0, 7'd0);
						a_n = a_n + 1'b1; a_be = '0; a_gs = gauge_q;
					end
					m = drive_msg(a_h, present_q, cdir_q, spd);
					a_ls = m.dir; a_buf[a_n] = m; a_n = a_n + 1'b1;
					a_re = '0;
				end
				if (!(a_ls == a_h && a_h == 4'b0000)) begin
					a_re = sat_add(a_re, el_q);
					if (a_re >= {12'd0, rsi_q}) begin
						a_re = '0;
						m = drive_msg(a_h, present_q, cdir_q, spd);
						a_ls = m.dir; a_buf[a_n] = m; a_n = a_n + 1'b1;
					end
				end
				if (!((!a_bo && gauge_q == GAUGE_FULL) || (a_bo && gauge_q == 7'd0))) begin
					a_go = 1'b1;
					a_be = sat_add(a_be, el_q);
				end
			end
			default: a_n = '0;
		endcase
	end

	// gauge update after the timing division
	logic [6:0]           b_g, b_gs;
	logic                 b_bo;
	logic [31:0]          b_be;
	msg_t                 b_buf [RES_MAX];
	logic [RES_IDX_W-1:0] b_n;

	always_comb begin
		logic [7:0] s8;
		b_bo = bon_q;
		b_be = belap_q;
		b_gs = gstart_q;
		b_n  = cnt_q;
		for (int i = 0; i < RES_MAX; i++)
			b_buf[i] = buf_q[i];
		s8 = {1'b0, gstart_q} + {1'b0, q7};
		if (bon_q)
			b_g = (q7 >= gstart_q) ? 7'd0 : gstart_q - q7;
		else
			b_g = (s8 >= {1'b0, GAUGE_FULL}) ? GAUGE_FULL : s8[6:0];
		if (bon_q && b_g == 7'd0) begin
			b_bo = 1'b0; b_buf[b_n] = mk(KIND_BOOST, 4'd0, 8'd0, 1'b0, 7'd0);
			b_n = b_n + 1'b1; b_be = '0; b_gs = b_g;
		end
		b_buf[b_n] = mk(KIND_GAUGE, 4'd0, 8'd0, b_bo, b_g);
		b_n = b_n + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q     <= 15'd4096;
			dz_q     <= 15'd1024;
			sfs_q    <= 8'd255;
			rsi_q    <= 20'd100000;
			drn_q    <= 26'd3000000;
			fil_q    <= 26'd10000000;
			held_q   <= '0;
			last_q   <= '0;
			bh_q     <= 1'b0;
			bon_q    <= 1'b0;
			gauge_q  <= GAUGE_FULL;
			gstart_q <= GAUGE_FULL;
			belap_q  <= '0;
			relap_q  <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TILT_RANGE: tr_q  <= cfg_data[14:0];
					CFG_DEADZONE:   dz_q  <= cfg_data[14:0];
					CFG_SPEED_FS:   sfs_q <= cfg_data[7:0];
					CFG_RESEND:     rsi_q <= cfg_data[19:0];
					CFG_DRAIN:      drn_q <= cfg_data[25:0];
					CFG_FILL:       fil_q <= cfg_data[25:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				cnt_q <= '0;
				idx_q <= '0;
			end
			if (cmd.eval_a) begin
				held_q   <= a_h;
				last_q   <= a_ls;
				bh_q     <= a_bh;
				bon_q    <= a_bo;
				gstart_q <= a_gs;
				belap_q  <= a_be;
				relap_q  <= a_re;
				cnt_q    <= a_n;
			end
			if (cmd.eval_b) begin
				gauge_q  <= b_g;
				bon_q    <= b_bo;
				belap_q  <= b_be;
				gstart_q <= b_gs;
				cnt_q    <= b_n;
			end
			if (cmd.emit_next)
				idx_q <= idx_q + 1'b1;
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= item.req_type;
			btn_q     <= item.button;
			el_q      <= item.elapsed_us;
			present_q <= item.accel_present;
			tilt_ok_q <= (item.accel_z > 16'sd0);
			y_q       <= clampr(ax17, r17);
			x_q       <= clampr(nay17, r17);
		end
		if (cmd.sq) begin
			cdir_q <= cdir_d;
			rem_q  <= $unsigned(xx) + $unsigned(yy);
			res_q  <= '0;
			bit_q  <= 32'h4000_0000;
		end
		if (cmd.sqrt_step) begin
			if (rem_q >= sq_t) begin
				rem_q <= rem_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			drem_q <= 23'(m15) * 23'(sfs_q);
			ddvs_q <= {1'b0, span, 7'd0};
			dquo_q <= '0;
		end
		if (cmd.div_step) begin
			if (drem_q >= ddvs_q) begin
				drem_q <= drem_q - ddvs_q;
				dquo_q <= {dquo_q[6:0], 1'b1};
			end else begin
				dquo_q <= {dquo_q[6:0], 1'b0};
			end
			ddvs_q <= ddvs_q >> 1;
		end
		if (cmd.gmul)
			prod_q <= 39'(belap_q) * 39'(GAUGE_FULL);
		if (cmd.gdiv_init) begin
			gover_q <= (tsel == 26'd0) || (prod_q >= {6'd0, tsel, 7'd0});
			goval_q <= (tsel == 26'd0) ? GAUGE_FULL : GAUGE_SAT;
			grem_q  <= prod_q[32:0];
			gdvs_q  <= {1'b0, tsel, 6'd0};
			gquo_q  <= '0;
		end
		if (cmd.gdiv_step) begin
			if (grem_q >= gdvs_q) begin
				grem_q <= grem_q - gdvs_q;
				gquo_q <= {gquo_q[5:0], 1'b1};
			end else begin
				gquo_q <= {gquo_q[5:0], 1'b0};
			end
			gdvs_q <= gdvs_q >> 1;
		end
		if (cmd.eval_a) begin
			for (int i = 0; i < RES_MAX; i++)
				buf_q[i] <= a_buf[i];
		end
		if (cmd.eval_b) begin
			for (int i = 0; i < RES_MAX; i++)
				buf_q[i] <= b_buf[i];
		end
	end

	assign res          = buf_q[idx_q];
	assign res_last     = (idx_q == cnt_q - 1'b1);
	assign sts.gauge_go = a_go;
	assign sts.empty    = (cnt_q == '0);
	assign sts.last     = res_last;

endmodule

@@ rtl/core/manual_drive_boost_controller_unit.sv @@
// an item is accepted only while idle; the block then runs the isqrt, the speed
//   divider and, on a gauge update, the gauge multiply and divider, then the results
// one item at a time: no new item is taken until its results are handed out
// the item's results then follow one per cycle while the sink is ready
// reset (arst_n low, asynchronous): registers to defaults, gauge full, no results pending
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// manual_drive_boost_controller_unit
// remote drive input logic: buttons, tilt steering and boost gauge messages
// -----------------------------------------------------------------------------
module manual_drive_boost_controller_unit
	import mdbc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	mdbc_req_if.sink   req,
	mdbc_rsp_if.source rsp,
	mdbc_cfg_if.sink   cfg
);

	cmd_t  cmd;
	sts_t  sts;
	item_t item;
	msg_t  res;
	logic  res_last;

	// the user keeps register writes to while the block is idle; writes are not gated
	assign cfg.ready = 1'b1;

	// pack the request fields for the datapath
	assign item.req_type      = req.req_type;
	assign item.button        = req.button;
	assign item.elapsed_us    = req.elapsed_us;
	assign item.accel_x       = req.accel_x;
	assign item.accel_y       = req.accel_y;
	assign item.accel_z       = req.accel_z;
	assign item.accel_present = req.accel_present;

	// sequencer: accepts an item, runs the isqrt, the speed divider and, on a gauge
	// update, the gauge divider, then hands out the buffered results one per handshake
	mdbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: holds the registers, drive state, gauge and the result buffer
	mdbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res       (res),
		.res_last  (res_last)
	);

	// result fields straight from the buffer entry being shown
	assign rsp.msg_kind    = res.kind;
	assign rsp.drive_dir   = res.dir;
	assign rsp.drive_speed = res.speed;
	assign rsp.boost_flag  = res.flag;
	assign rsp.gauge_level = res.level;
	assign rsp.last_of_run = res_last;

endmodule

@@ rtl/core/mdbc_chk.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mdbc_chk
// port checker for the manual drive boost controller
// -----------------------------------------------------------------------------
module mdbc_chk
	import mdbc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] msg_kind,
	input logic [7:0] drive_speed,
	input logic [6:0] gauge_level,
	input logic       last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(msg_kind) && $stable(gauge_level))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("item taken while results pending");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && last_of_run |=> !rsp_valid)
		else $error("result after end of run");

	a_gauge: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> gauge_level <= GAUGE_FULL)
		else $error("gauge above full");

	a_speed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && msg_kind != KIND_SPEED |-> drive_speed == 8'd0)
		else $error("speed on wrong message kind");

endmodule

bind manual_drive_boost_controller_unit mdbc_chk u_mdbc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.msg_kind    (rsp.msg_kind),
	.drive_speed (rsp.drive_speed),
	.gauge_level (rsp.gauge_level),
	.last_of_run (rsp.last_of_run)
);

@@ dv/tb_manual_drive_boost_controller_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_manual_drive_boost_controller_unit
// self-checking bench: button, tilt and tick items go in through the request
// channel, an in-bench predictor tracks drive, boost and gauge state, and every
// message that comes out is checked against the oldest predicted message
// -----------------------------------------------------------------------------
module tb_manual_drive_boost_controller_unit;
	import mdbc_pkg::*;

	// one predicted message, last flag included
	typedef struct {
		logic [2:0] kind;
		logic [3:0] dir;
		logic [7:0] speed;
		logic       flag;
		logic [6:0] level;
		logic       last;
	} exp_msg_t;

	logic clk;
	logic arst_n;
	mdbc_req_if req ();
	mdbc_rsp_if rsp ();
	mdbc_cfg_if cfg ();

	manual_drive_boost_controller_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// predictor copy of the registers
	logic [14:0] p_range;
	logic [14:0] p_dead;
	logic [7:0]  p_fs;
	logic [19:0] p_resend;
	logic [25:0] p_drain;
	logic [25:0] p_fill;
	// predictor copy of the state
	logic [3:0]  p_held;
	logic [3:0]  p_last_sent;
	logic        p_bheld;
	logic        p_bon;
	logic [6:0]  p_gauge;
	logic [6:0]  p_gstart;
	logic [31:0] p_belapsed;
	logic [31:0] p_relapsed;
	// tilt of the current item
	logic [3:0]  t_dir;
	logic [7:0]  t_speed;
	logic        t_present;

	exp_msg_t    pending_msgs[$];
	exp_msg_t    run_msgs[$];
	int          errors;
	int          n_items;
	int          n_msgs;
	int          cycle_cnt;
	bit          idle_on;

	// ---------------------------------------------------------------- predictor
	function automatic logic [31:0] sqrt_floor(input logic [31:0] v);
		logic [31:0] res;
		logic [31:0] b;
		res = 0;
		b = 32'h4000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [3:0] button_dir(input logic [2:0] b);
		case (b)
			KEY_UP:    return DIR_UP;
			KEY_DOWN:  return DIR_DOWN;
			KEY_LEFT:  return DIR_LEFT;
			KEY_RIGHT: return DIR_RIGHT;
			default:   return 4'd0;
		endcase
	endfunction

	task automatic eval_tilt(input item_t it);
		int r, d, ax, ay, x, y;
		logic [31:0] mag, span, m;
		r = p_range;
		d = p_dead;
		ax = it.accel_x;
		ay = it.accel_y;
		t_present = it.accel_present;
		t_dir = 0;
		t_speed = 0;
		if (it.accel_z <= 0) return;
		y = ax > r ? r : (ax < -r ? -r : ax);
		x = -ay > r ? r : (-ay < -r ? -r : -ay);
		if (t_present) begin
			if (y < -d) t_dir |= DIR_RIGHT;
			else if (y > d) t_dir |= DIR_LEFT;
			if (x < -d) t_dir |= DIR_DOWN;
			else if (x > d) t_dir |= DIR_UP;
		end
		if (r <= d) return;
		span = r - d;
		mag = sqrt_floor(32'(x * x) + 32'(y * y));
		m = (mag > d) ? mag - d : 0;
		if (m > span) m = span;
		t_speed = 8'((m * p_fs) / span);
	endtask

	task automatic push_msg(input logic [2:0] k, input logic [3:0] dr, input logic [7:0] sp,
			input logic fl, input logic [6:0] lv);
		exp_msg_t e;
		if (run_msgs.size() >= RES_MAX) return;
		e.kind = k;
		e.dir = dr;
		e.speed = sp;
		e.flag = fl;
		e.level = lv;
		e.last = 1'b0;
		run_msgs.push_back(e);
	endtask

	task automatic drive_msg();
		if (p_held == 0 && t_present && t_speed != 0) begin
			p_last_sent = t_dir;
			push_msg(KIND_SPEED, t_dir, t_speed, 1'b0, 7'd0);
		end else begin
			p_last_sent = p_held;
			push_msg(KIND_DRIVE, p_held, 8'd0, 1'b0, 7'd0);
		end
	endtask

	task automatic boost_msg(input logic on);
		p_bon = on;
		push_msg(KIND_BOOST, 4'd0, 8'd0, on, 7'd0);
		p_belapsed = 0;
		p_gstart = p_gauge;
	endtask

	// works out the messages of one item and queues them
	task automatic predict_messages(input item_t it);
		logic [63:0] q;
		run_msgs.delete();
		eval_tilt(it);
		if (it.req_type == REQ_PRESS) begin
			if (it.button == KEY_A) begin
				p_bheld = 1;
				if (p_held != 0) boost_msg(p_gauge > 0 ? 1'b1 : p_bon);
			end else if (it.button == KEY_B) begin
				push_msg(KIND_HONK, 4'd0, 8'd0, 1'b0, 7'd0);
			end else if (it.button != KEY_MENU) begin
				if (p_bheld) boost_msg(p_gauge > 0 ? 1'b1 : p_bon);
				p_held |= button_dir(it.button);
				drive_msg();
				p_relapsed = 0;
			end
		end else if (it.req_type == REQ_RELEASE) begin
			if (it.button == KEY_A) begin
				p_bheld = 0;
				if (p_bon) boost_msg(1'b0);
			end else begin
				p_held &= ~button_dir(it.button);
				drive_msg();
				p_relapsed = 0;
			end
			if (p_held == 0 && t_dir == 0 && p_bon) boost_msg(1'b0);
		end else if (it.req_type == REQ_TICK) begin
			if (t_present) begin
				if (p_bheld && t_dir != 0 && !p_bon && p_gauge > 0) boost_msg(1'b1);
				if (p_held == 0 && t_dir == 0 && p_bon) boost_msg(1'b0);
				drive_msg();
				p_relapsed = 0;
			end
			if (!(p_last_sent == p_held && p_held == 0)) begin
				p_relapsed = sat_sum(p_relapsed, 32'(it.elapsed_us));
				if (p_relapsed >= p_resend) begin
					p_relapsed = 0;
					drive_msg();
				end
			end
			// a full gauge at rest or an empty one under boost is left alone
			if (!((!p_bon && p_gauge == GAUGE_FULL) || (p_bon && p_gauge == 0))) begin
				p_belapsed = sat_sum(p_belapsed, 32'(it.elapsed_us));
				if (p_bon) begin
					q = p_drain != 0 ? (64'(p_belapsed) * 100) / p_drain : 64'd100;
					p_gauge = (q >= p_gstart) ? 7'd0 : 7'(p_gstart - q);
				end else begin
					q = p_fill != 0 ? (64'(p_belapsed) * 100) / p_fill : 64'd100;
					p_gauge = (64'(p_gstart) + q >= GAUGE_FULL) ? GAUGE_FULL
						: 7'(p_gstart + q);
				end
				if (p_bon && p_gauge == 0) boost_msg(1'b0);
				push_msg(KIND_GAUGE, 4'd0, 8'd0, p_bon, p_gauge);
			end
		end
		if (run_msgs.size() > 0) run_msgs[run_msgs.size() - 1].last = 1'b1;
		foreach (run_msgs[i]) pending_msgs.push_back(run_msgs[i]);
	endtask

	// ---------------------------------------------------------------- drivers
	task automatic random_gap();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 18);
			repeat (n) @(negedge clk);
		end
	endtask

	// sends one item and predicts its messages at acceptance
	task automatic send_item(input item_t it);
		// move to a falling edge past the previous drop of valid
		@(negedge clk);
		random_gap();
		req.valid <= 1'b1;
		req.req_type <= it.req_type;
		req.button <= it.button;
		req.elapsed_us <= it.elapsed_us;
		req.accel_x <= it.accel_x;
		req.accel_y <= it.accel_y;
		req.accel_z <= it.accel_z;
		req.accel_present <= it.accel_present;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_messages(it);
		n_items++;
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (pending_msgs.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [25:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			CFG_TILT_RANGE: p_range = val[14:0];
			CFG_DEADZONE:   p_dead = val[14:0];
			CFG_SPEED_FS:   p_fs = val[7:0];
			CFG_RESEND:     p_resend = val[19:0];
			CFG_DRAIN:      p_drain = val;
			CFG_FILL:       p_fill = val;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [14:0] rg, input logic [14:0] dz, input logic [7:0] fs,
			input logic [19:0] rs, input logic [25:0] dr, input logic [25:0] fl);
		drain_and_settle();
		write_reg(CFG_TILT_RANGE, 26'(rg));
		write_reg(CFG_DEADZONE, 26'(dz));
		write_reg(CFG_SPEED_FS, 26'(fs));
		write_reg(CFG_RESEND, 26'(rs));
		write_reg(CFG_DRAIN, dr);
		write_reg(CFG_FILL, fl);
	endtask

	function automatic item_t mk(input logic [1:0] t, input logic [2:0] b, input logic [19:0] el,
			input int ax, input int ay, input int az, input logic pr);
		item_t it;
		it.req_type = t;
		it.button = b;
		it.elapsed_us = el;
		it.accel_x = 16'(ax);
		it.accel_y = 16'(ay);
		it.accel_z = 16'(az);
		it.accel_present = pr;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int sel;
		sel = $urandom_range(0, 9);
		it.req_type = sel < 3 ? REQ_PRESS : (sel < 6 ? REQ_RELEASE : REQ_TICK);
		if ($urandom_range(0, 40) == 0) it.req_type = REQ_NONE;
		it.button = 3'($urandom_range(0, 7));
		it.elapsed_us = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 300000));
		it.accel_x = 16'($urandom);
		it.accel_y = 16'($urandom);
		if ($urandom_range(0, 1)) begin
			it.accel_x = 16'($signed($urandom_range(0, 12000)) - 6000);
			it.accel_y = 16'($signed($urandom_range(0, 12000)) - 6000);
		end
		it.accel_z = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 20000));
		it.accel_present = $urandom_range(0, 4) != 0;
		return it;
	endfunction

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin
		exp_msg_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_msgs.size() == 0) begin
				$error("unexpected message kind %0d", rsp.msg_kind);
				errors++;
			end else begin
				e = pending_msgs.pop_front();
				n_msgs++;
				if (rsp.msg_kind !== e.kind) begin
					$error("msg_kind expected %0d got %0d", e.kind, rsp.msg_kind);
					errors++;
				end
				if (rsp.drive_dir !== e.dir) begin
					$error("drive_dir expected %0d got %0d", e.dir, rsp.drive_dir);
					errors++;
				end
				if (rsp.drive_speed !== e.speed) begin
					$error("drive_speed expected %0d got %0d", e.speed, rsp.drive_speed);
					errors++;
				end
				if (rsp.boost_flag !== e.flag) begin
					$error("boost_flag expected %0d got %0d", e.flag, rsp.boost_flag);
					errors++;
				end
				if (rsp.gauge_level !== e.level) begin
					$error("gauge_level expected %0d got %0d", e.level, rsp.gauge_level);
					errors++;
				end
				if (rsp.last_of_run !== e.last) begin
					$error("last_of_run expected %0d got %0d", e.last, rsp.last_of_run);
					errors++;
				end
			end
		end
	end

	// receiver stalls in bursts while idling is on
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// watchdog: 340 items, with the longest gaps and five stalled messages each,
	// stay far below this
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 400000) begin
			$display("manual_drive_boost_controller_unit regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	task automatic test_buttons();
		// every press, every release but B, boost held while steering, honk, menu
		send_item(mk(REQ_PRESS, KEY_B, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_MENU, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_OTHER, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_A, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_UP, 0, 0, 0, 0, 1));
		send_item(mk(REQ_PRESS, KEY_LEFT, 0, 0, 0, 0, 1));
		send_item(mk(REQ_TICK, KEY_A, 20'hFFFFF, 0, 0, 1, 0));
		send_item(mk(REQ_TICK, KEY_A, 20'hFFFFF, 0, 0, 1, 0));
		send_item(mk(REQ_TICK, KEY_A, 20'hFFFFF, 0, 0, 1, 0));
		// boost pressed again with an empty gauge
		send_item(mk(REQ_PRESS, KEY_A, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_MENU, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_UP, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_LEFT, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_A, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_DOWN, 0, 0, 0, 0, 0));
		send_item(mk(REQ_PRESS, KEY_RIGHT, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_OTHER, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_DOWN, 0, 0, 0, 0, 0));
		send_item(mk(REQ_RELEASE, KEY_RIGHT, 0, 0, 0, 0, 0));
		// unknown request type
		send_item(mk(REQ_NONE, KEY_OTHER, 20'hFFFFF, -1, -1, -1, 1));
	endtask

	task automatic test_tilt_extremes();
		// clamped axes on three corners, z at zero and negative, sensor absent
		send_item(mk(REQ_TICK, KEY_A, 1, 32767, -32768, 32767, 1));
		send_item(mk(REQ_TICK, KEY_A, 1, -32768, 32767, 1, 1));
		send_item(mk(REQ_TICK, KEY_A, 1, 32767, 32767, 0, 1));
		send_item(mk(REQ_TICK, KEY_A, 1, 32767, 32767, -32768, 1));
		send_item(mk(REQ_TICK, KEY_A, 1, 500, -500, 100, 1));
		send_item(mk(REQ_TICK, KEY_A, 1, 32767, 0, 5, 0));
		send_item(mk(REQ_PRESS, KEY_A, 0, 0, 0, 0, 0));
		send_item(mk(REQ_TICK, KEY_A, 0, 9000, 0, 5, 1));
		send_item(mk(REQ_TICK, KEY_A, 0, 0, 0, 5, 1));
		send_item(mk(REQ_RELEASE, KEY_A, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(input int count);
		item_t it;
		int k;
		for (k = 0; k < count; k++) begin
			// mostly steer-and-boost sequences, with noise in between
			if ($urandom_range(0, 2) == 0) it = rand_item();
			else begin
				it = rand_item();
				it.req_type = REQ_TICK;
				it.accel_present = 1'b1;
			end
			send_item(it);
		end
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		arst_n = 1'b0;
		errors = 0;
		n_items = 0;
		n_msgs = 0;
		cycle_cnt = 0;
		idle_on = 1'b1;
		req.valid = 1'b0;
		req.req_type = REQ_PRESS;
		req.button = KEY_A;
		req.elapsed_us = 0;
		req.accel_x = 0;
		req.accel_y = 0;
		req.accel_z = 0;
		req.accel_present = 0;
		cfg.valid = 1'b0;
		cfg.index = CFG_TILT_RANGE;
		cfg.data = 0;
		// reset defaults of the predictor
		p_range = 4096;
		p_dead = 1024;
		p_fs = 255;
		p_resend = 100000;
		p_drain = 3000000;
		p_fill = 10000000;
		p_held = 0;
		p_last_sent = 0;
		p_bheld = 0;
		p_bon = 0;
		p_gauge = GAUGE_FULL;
		p_gstart = GAUGE_FULL;
		p_belapsed = 0;
		p_relapsed = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_buttons();
		test_tilt_extremes();
		// hold off until every predicted message is out
		drain_and_settle();
		test_random(60);

		// smallest range, deadzone at range, quick timers
		write_all(15'd1, 15'd1, 8'd1, 20'd1, 26'd1, 26'd1);
		test_random(40);
		// largest values, zero deadzone
		write_all(15'd32767, 15'd0, 8'd255, 20'hFFFFF, 26'h3FFFFFF, 26'h3FFFFFF);
		test_random(40);
		// deadzone above range, then mid settings
		write_all(15'd100, 15'd32766, 8'd77, 20'd50000, 26'd200000, 26'd400000);
		test_random(40);
		write_all(15'd2000, 15'd300, 8'd200, 20'd20000, 26'd300000, 26'd900000);
		test_random(90);
		// last stretch with no stalls on either side
		idle_on = 1'b0;
		test_random(40);

		while (pending_msgs.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("covered %0d items and %0d messages over five register settings",
			n_items, n_msgs);
		$display("buttons, boost and gauge drain/refill, clamped tilt and resend timing");
		if (errors == 0) begin
			$display("manual_drive_boost_controller_unit regression: pass");
		end else begin
			$display("manual_drive_boost_controller_unit regression: fail");
		end
		$finish;
	end

endmodule
